// ===== rtl/core/json_token_stream_serializer_top_defines.svh =====
// Assertion macros shared by the serializer RTL.
`ifndef JSON_TOKEN_STREAM_SERIALIZER_TOP_DEFINES_SVH
`define JSON_TOKEN_STREAM_SERIALIZER_TOP_DEFINES_SVH

// Condition that holds at every edge out of reset.
`define JTSS_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("serializer check failed");

// Same-cycle implication.
`define JTSS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("serializer check failed");

// Next-cycle implication.
`define JTSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("serializer check failed");

`endif

// ===== rtl/core/jtss_pkg.sv =====
// Types, codes and escape table of the JSON token serializer.
`default_nettype none
package jtss_pkg;

    localparam int          MAX_DEPTH_DEF = 8;
    localparam logic [15:0] CAP_RESET     = 16'd4096;
    localparam int          BUF_DEPTH     = 21;
    localparam int          BCD_DIGITS    = 20;
    localparam logic        REG_CAPACITY  = 1'b0;

    localparam logic [3:0] FN_START     = 4'd0;
    localparam logic [3:0] FN_OBJ_OPEN  = 4'd1;
    localparam logic [3:0] FN_OBJ_CLOSE = 4'd2;
    localparam logic [3:0] FN_ARR_OPEN  = 4'd3;
    localparam logic [3:0] FN_ARR_CLOSE = 4'd4;
    localparam logic [3:0] FN_KEY_OPEN  = 4'd5;
    localparam logic [3:0] FN_STR_OPEN  = 4'd6;
    localparam logic [3:0] FN_CHAR      = 4'd7;
    localparam logic [3:0] FN_KEY_CLOSE = 4'd8;
    localparam logic [3:0] FN_STR_CLOSE = 4'd9;
    localparam logic [3:0] FN_INT       = 4'd10;
    localparam logic [3:0] FN_BOOL      = 4'd11;
    localparam logic [3:0] FN_NULL      = 4'd12;
    localparam logic [3:0] FN_FINISH    = 4'd13;

    // Chunk of up to six bytes, first byte in the low bits.
    typedef struct packed {
        logic [2:0]  len;
        logic [47:0] bytes;
    } t_chunk;

    function automatic logic [7:0] hex_lc(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) r = 8'h30 + {4'h0, n};
        else           r = 8'h57 + {4'h0, n};
        return r;
    endfunction

    function automatic t_chunk esc_chunk(input logic [7:0] c);
        t_chunk r;
        r.len   = 3'd2;
        r.bytes = '0;
        case (c)
            8'h22:   r.bytes[15:0] = {8'h22, 8'h5c};
            8'h5c:   r.bytes[15:0] = {8'h5c, 8'h5c};
            8'h0a:   r.bytes[15:0] = {8'h6e, 8'h5c};
            8'h0d:   r.bytes[15:0] = {8'h72, 8'h5c};
            8'h09:   r.bytes[15:0] = {8'h74, 8'h5c};
            default: begin
                if (c < 8'h20) begin
                    r.len   = 3'd6;
                    r.bytes = {hex_lc(c[3:0]), hex_lc(c[7:4]), 8'h30, 8'h30, 8'h75, 8'h5c};
                end else begin
                    r.len   = 3'd1;
                    r.bytes = {40'h0, c};
                end
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/json_token_stream_serializer_top.sv =====
// JSON token serializer: one token in, its escaped output bytes out, one beat per byte.
//
// Each accepted token is worked by a small sequencer and its bytes are gathered
// into a 21-byte buffer before the first output beat, so every beat carries the
// overflow flag as it stands after the token. The sequencer writes the token's
// bytes into the buffer one per copy step, then gives one output beat per byte;
// an integer first runs shift-and-add-3 binary-to-decimal conversion on the digit
// unit and then a leading-zero scan. The input stalls from the accepting edge until
// the last beat is taken. Tokens that write nothing give one beat with byte_valid
// low. Capacity sits at byte address 0 of the APB port, reset 4096.
`default_nettype none
`include "json_token_stream_serializer_top_defines.svh"
module json_token_stream_serializer_top
    import jtss_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [3:0]         i_func,
    input  wire logic [7:0]         i_ch,
    input  wire logic signed [63:0] i_int_value,
    input  wire logic               i_bool_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic      [7:0]         o_out_byte,
    output logic                    o_byte_valid,
    output logic                    o_last,
    output logic                    o_overflow,
    output logic      [15:0]        o_finish_length
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int BW = $clog2(BUF_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_NEXT, S_PUT, S_COPY, S_CONV, S_SCAN, S_EMIT
    } t_state;

    t_state              r_state;
    logic [15:0]         r_cap;
    logic [15:0]         r_wl;
    logic                r_err;
    logic [DW-1:0]       r_depth;
    logic [MAX_DEPTH-1:0] r_first;
    logic                r_pk;
    logic [3:0]          r_func;
    logic [7:0]          r_ch;
    logic [63:0]         r_ival;
    logic                r_bval;
    logic [1:0]          r_phase;
    logic [15:0]         r_flen;
    logic [47:0]         r_chk;
    logic [4:0]          r_len;
    logic                r_intm;
    logic                r_negp;
    logic [4*BCD_DIGITS-1:0] r_bcd;
    logic [63:0]         r_mag;
    logic [5:0]          r_it;
    logic [4:0]          r_nd;
    logic [7:0]          r_buf [BUF_DEPTH];
    logic [BW-1:0]       r_cnt;
    logic [BW-1:0]       r_rd;

    logic                in_acc, out_acc, cfg_wr;
    logic [DW-1:0]       dm1;
    logic                sep_put;
    logic                fits;
    logic [7:0]          copy_byte;
    logic [4*BCD_DIGITS-1:0] bcd_adj;
    t_chunk              esc;
    logic [63:0]         mag_in;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_CAPACITY) ? {16'h0, r_cap} : 32'h0;
    assign o_stall = (r_state != S_IDLE);

    assign dm1     = r_depth - DW'(1);
    assign sep_put = !r_pk && (r_depth != '0) && !r_first[dm1[IW-1:0]];
    assign fits    = !r_err && ({1'b0, r_wl} + {12'h0, r_len} + 17'd1 <= {1'b0, r_cap});
    assign esc     = esc_chunk(r_ch);
    assign mag_in  = r_ival[63] ? (~r_ival + 64'd1) : r_ival;

    always_comb begin
        if (!r_intm)    copy_byte = r_chk[7:0];
        else if (r_negp) copy_byte = 8'h2d;
        else            copy_byte = {4'h3, r_bcd[4*BCD_DIGITS-1 -: 4]};
    end

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) bcd_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            else                         bcd_adj[4*d +: 4] = r_bcd[4*d +: 4];
        end
    end

    assign o_valid         = (r_state == S_EMIT);
    assign o_byte_valid    = (r_cnt != '0);
    assign o_out_byte      = (r_cnt != '0) ? r_buf[r_rd[4:0]] : 8'h00;
    assign o_last          = (r_cnt == '0) || (r_rd == r_cnt - BW'(1));
    assign o_overflow      = r_err;
    assign o_finish_length = r_flen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= CAP_RESET;
            r_wl    <= '0;
            r_err   <= 1'b0;
            r_depth <= '0;
            r_first <= '0;
            r_pk    <= 1'b0;
            r_phase <= '0;
            r_cnt   <= '0;
            r_rd    <= '0;
            r_flen  <= '0;
            r_intm  <= 1'b0;
            r_negp  <= 1'b0;
        end else begin
            if (cfg_wr && paddr[2] == REG_CAPACITY) r_cap <= pwdata[15:0];
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_func  <= i_func;
                        r_ch    <= i_ch;
                        r_ival  <= i_int_value;
                        r_bval  <= i_bool_value;
                        r_phase <= '0;
                        r_cnt   <= '0;
                        r_rd    <= '0;
                        r_flen  <= '0;
                        r_intm  <= 1'b0;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_state <= S_EMIT;
                    r_intm  <= 1'b0;
                    r_phase <= r_phase + 2'd1;
                    case (r_func)
                        FN_START: begin
                            r_wl    <= '0;
                            r_err   <= (r_cap == '0);
                            r_depth <= '0;
                            r_first <= '0;
                            r_pk    <= 1'b0;
                        end
                        FN_OBJ_OPEN, FN_ARR_OPEN, FN_KEY_OPEN, FN_STR_OPEN,
                        FN_INT, FN_BOOL, FN_NULL: begin
                            if (r_phase == 2'd0) begin
                                // separator: key just written, else comma unless first
                                r_state <= S_NEXT;
                                if (r_pk) begin
                                    r_pk <= 1'b0;
                                end else if (r_depth != '0) begin
                                    r_first[dm1[IW-1:0]] <= 1'b0;
                                end
                                if (sep_put) begin
                                    r_chk   <= 48'h2c;
                                    r_len   <= 5'd1;
                                    r_state <= S_PUT;
                                end
                            end else if (r_phase == 2'd1) begin
                                r_state <= S_PUT;
                                r_len   <= 5'd1;
                                case (r_func)
                                    FN_OBJ_OPEN: r_chk <= 48'h7b;
                                    FN_ARR_OPEN: r_chk <= 48'h5b;
                                    FN_BOOL: begin
                                        if (r_bval) begin
                                            r_chk <= 48'h65757274;
                                            r_len <= 5'd4;
                                        end else begin
                                            r_chk <= 48'h65736c6166;
                                            r_len <= 5'd5;
                                        end
                                    end
                                    FN_NULL: begin
                                        r_chk <= 48'h6c6c756e;
                                        r_len <= 5'd4;
                                    end
                                    FN_INT: begin
                                        r_bcd   <= '0;
                                        r_mag   <= mag_in;
                                        r_it    <= '0;
                                        r_state <= S_CONV;
                                    end
                                    default: r_chk <= 48'h22;
                                endcase
                            end else if ((r_func == FN_OBJ_OPEN || r_func == FN_ARR_OPEN)
                                         && r_phase == 2'd2) begin
                                if (r_depth >= DW'(MAX_DEPTH)) begin
                                    r_err <= 1'b1;
                                end else begin
                                    r_first[r_depth[IW-1:0]] <= 1'b1;
                                    r_depth <= r_depth + DW'(1);
                                end
                            end
                        end
                        FN_OBJ_CLOSE, FN_ARR_CLOSE: begin
                            if (r_phase == 2'd0) begin
                                if (r_depth == '0) begin
                                    r_err <= 1'b1;
                                end else begin
                                    r_depth <= dm1;
                                    r_chk   <= (r_func == FN_OBJ_CLOSE) ? 48'h7d : 48'h5d;
                                    r_len   <= 5'd1;
                                    r_state <= S_PUT;
                                end
                            end
                        end
                        FN_CHAR: begin
                            if (r_phase == 2'd0) begin
                                r_chk   <= esc.bytes;
                                r_len   <= {2'b00, esc.len};
                                r_state <= S_PUT;
                            end
                        end
                        FN_KEY_CLOSE: begin
                            if (r_phase == 2'd0) begin
                                r_chk   <= 48'h22;
                                r_len   <= 5'd1;
                                r_state <= S_PUT;
                            end else if (r_phase == 2'd1) begin
                                r_chk   <= 48'h3a;
                                r_len   <= 5'd1;
                                r_state <= S_PUT;
                            end else begin
                                r_pk <= 1'b1;
                            end
                        end
                        FN_STR_CLOSE: begin
                            if (r_phase == 2'd0) begin
                                r_chk   <= 48'h22;
                                r_len   <= 5'd1;
                                r_state <= S_PUT;
                            end
                        end
                        FN_FINISH: begin
                            r_flen <= (r_err || r_depth != '0 || r_pk) ? 16'h0 : r_wl;
                        end
                        default: ;
                    endcase
                end
                S_PUT: begin
                    if (fits) begin
                        r_wl    <= r_wl + {11'h0, r_len};
                        r_state <= S_COPY;
                    end else begin
                        r_err   <= 1'b1;
                        r_state <= S_NEXT;
                    end
                end
                S_COPY: begin
                    r_buf[r_cnt[4:0]] <= copy_byte;
                    r_cnt <= r_cnt + BW'(1);
                    r_len <= r_len - 5'd1;
                    if (!r_intm)      r_chk <= {8'h0, r_chk[47:8]};
                    else if (r_negp)  r_negp <= 1'b0;
                    else              r_bcd <= {r_bcd[4*BCD_DIGITS-5:0], 4'h0};
                    if (r_len == 5'd1) r_state <= S_NEXT;
                end
                S_CONV: begin
                    {r_bcd, r_mag} <= {bcd_adj, r_mag} << 1;
                    r_it <= r_it + 6'd1;
                    if (r_it == 6'd63) begin
                        r_nd    <= 5'(BCD_DIGITS);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // drop leading zero digits, keep at least one
                    if (r_bcd[4*BCD_DIGITS-1 -: 4] == 4'h0 && r_nd > 5'd1) begin
                        r_bcd <= {r_bcd[4*BCD_DIGITS-5:0], 4'h0};
                        r_nd  <= r_nd - 5'd1;
                    end else begin
                        r_intm  <= 1'b1;
                        r_negp  <= r_ival[63];
                        r_len   <= r_nd + {4'h0, r_ival[63]};
                        r_state <= S_PUT;
                    end
                end
                S_EMIT: begin
                    if (out_acc) begin
                        if (o_last) r_state <= S_IDLE;
                        else        r_rd <= r_rd + BW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `JTSS_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= BW'(BUF_DEPTH))
    `JTSS_ASSERT_IMPL(a_empty_is_last, i_clk, i_rst_n, o_valid && !o_byte_valid, o_last)
    `JTSS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_stall)
    `JTSS_ASSERT_NEXT(a_done_after_last, i_clk, i_rst_n, out_acc && o_last, !o_valid)
    `JTSS_ASSERT_ALWAYS(a_depth_bound, i_clk, i_rst_n, r_depth <= DW'(MAX_DEPTH))

endmodule
`default_nettype wire
